### design/fdps_pkg.sv
// shared types and constants of the flag driven path segmenter
package fdps_pkg;

   // segmentation actions
   localparam logic [2:0] ACT_SPLIT      = 3'd0;
   localparam logic [2:0] ACT_REMOVE     = 3'd1;
   localparam logic [2:0] ACT_DISCONNECT = 3'd2;
   localparam logic [2:0] ACT_PARTITION  = 3'd3;
   localparam logic [2:0] ACT_SWITCH     = 3'd4;

   // initial run state modes
   localparam logic [1:0] MODE_CONST          = 2'd0;
   localparam logic [1:0] MODE_CONST_PRESERVE = 2'd1;
   localparam logic [1:0] MODE_FIRST          = 2'd2;
   localparam logic [1:0] MODE_FIRST_PRESERVE = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [2:0] CSR_SPLIT_ACTION  = 3'd0;
   localparam logic [2:0] CSR_INITIAL_MODE  = 3'd1;
   localparam logic [2:0] CSR_INITIAL_VALUE = 3'd2;
   localparam logic [2:0] CSR_INCLUSIVE     = 3'd3;
   localparam logic [2:0] CSR_CLOSED_LOOP   = 3'd4;
   localparam logic [2:0] CSR_OMIT_SINGLE   = 3'd5;

   localparam logic [16:0] CNT_MAX = 17'h1FFFF;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [2:0] split_action;
      logic [1:0] initial_mode;
      logic       initial_value;
      logic       inclusive;
      logic       closed_loop;
      logic       omit_single;
   } cfg_type;

   typedef struct packed {
      logic [15:0] seg_start;
      logic [16:0] seg_count;
      logic        appends_first;
      logic        wraps_to_start;
      logic        whole_input;
      logic        partition_even;
      logic        last_of_run;
   } rsp_item_type;

   // up to three results from one request, slot 0 first
   typedef struct packed {
      logic [2:0]              valid;
      rsp_item_type [2:0]      item;
   } push_type;

   typedef struct packed {
      logic path_idle;
   } core_status_type;

   typedef struct packed {
      logic [2:0] count;
   } queue_status_type;

endpackage

### design/fdps_csr.sv
// configuration registers behind the apb-style port
module fdps_csr
   import fdps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;

   assign index  = paddr[4:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (index)
            CSR_SPLIT_ACTION:  cfg_in.split_action  = pwdata[2:0];
            CSR_INITIAL_MODE:  cfg_in.initial_mode  = pwdata[1:0];
            CSR_INITIAL_VALUE: cfg_in.initial_value = pwdata[0];
            CSR_INCLUSIVE:     cfg_in.inclusive     = pwdata[0];
            CSR_CLOSED_LOOP:   cfg_in.closed_loop   = pwdata[0];
            CSR_OMIT_SINGLE:   cfg_in.omit_single   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_SPLIT_ACTION:  prdata = {29'd0, cfg_ff.split_action};
         CSR_INITIAL_MODE:  prdata = {30'd0, cfg_ff.initial_mode};
         CSR_INITIAL_VALUE: prdata = {31'd0, cfg_ff.initial_value};
         CSR_INCLUSIVE:     prdata = {31'd0, cfg_ff.inclusive};
         CSR_CLOSED_LOOP:   prdata = {31'd0, cfg_ff.closed_loop};
         CSR_OMIT_SINGLE:   prdata = {31'd0, cfg_ff.omit_single};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/fdps_core.sv
// segment tracking state and the per-point update
module fdps_core
   import fdps_pkg::*;
#(
   parameter int MAX_POINTS = 65536
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            point_flag,
   input  logic            last_point,
   input  cfg_type         cfg,
   output push_type        push,
   output core_status_type status
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int NW = (CW + 1 > 17) ? CW + 1 : 17;
   localparam logic [CW-1:0] MAX_PC = CW'(MAX_POINTS);

   typedef struct packed {
      logic [CW-1:0] pc;
      logic          open;
      logic [CW-1:0] ostart;
      logic [16:0]   ocnt;
      logic          oeven;
      logic          run;
      logic          par;
      logic [1:0]    segs;
      logic          fpf;
      logic          hv;
      logic [CW-1:0] hstart;
      logic [16:0]   hcnt;
      logic          heven;
   } state_type;

   typedef struct packed {
      logic          v;
      logic [CW-1:0] start;
      logic [16:0]   cnt;
      logic          even;
   } pend_type;

   typedef struct packed {
      state_type st;
      pend_type  pend;
   } work_type;

   localparam state_type ST_RESET = '{par: 1'b1, default: '0};

   state_type st_ff;
   state_type st_in;
   push_type  res;

   function automatic logic [16:0] sat_add(logic [16:0] a, logic [16:0] b);
      logic [17:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[17] ? CNT_MAX : s[16:0];
   endfunction

   function automatic work_type open_new(work_type w, logic [CW-1:0] idx);
      work_type r;
      r = w;
      r.st.open   = 1'b1;
      r.st.ostart = idx;
      r.st.ocnt   = '0;
      r.st.oeven  = 1'b0;
      if (r.st.segs < 2'd2) r.st.segs = r.st.segs + 2'd1;
      return r;
   endfunction

   function automatic work_type extend(work_type w, logic [CW-1:0] idx);
      work_type r;
      r = w;
      if (!r.st.open) r = open_new(r, idx);
      r.st.ocnt = sat_add(r.st.ocnt, 17'd1);
      return r;
   endfunction

   function automatic work_type close_open(work_type w, logic extra, logic loop);
      work_type    r;
      logic [16:0] c;
      r = w;
      c = sat_add(r.st.ocnt, {16'd0, extra});
      if (r.st.open) begin
         // first segment of a loop starting on an unflagged point 0 waits for the end
         if (r.st.segs == 2'd1 && loop && r.st.ostart == '0 && !r.st.fpf && !r.st.hv) begin
            r.st.hv     = 1'b1;
            r.st.hstart = r.st.ostart;
            r.st.hcnt   = c;
            r.st.heven  = r.st.oeven;
         end else begin
            r.pend.v     = 1'b1;
            r.pend.start = r.st.ostart;
            r.pend.cnt   = c;
            r.pend.even  = r.st.oeven;
         end
         r.st.open = 1'b0;
      end
      return r;
   endfunction

   always_comb begin
      work_type      w;
      logic [CW-1:0] idx;
      logic [CW:0]   n;
      logic [16:0]   c;
      logic          wrap;
      logic          app;

      w.st   = st_ff;
      w.pend = '0;
      res    = '0;
      st_in  = st_ff;
      idx    = st_ff.pc;
      n      = {1'b0, idx} + {{CW{1'b0}}, 1'b1};
      c      = '0;
      wrap   = 1'b0;
      app    = 1'b0;

      if (idx == '0 && last_point) begin
         // single-point path
         res.valid[0]                = !cfg.omit_single;
         res.item[0].seg_count       = 17'd1;
         res.item[0].whole_input     = 1'b1;
         res.item[0].last_of_run     = 1'b1;
         st_in                       = ST_RESET;
      end else begin
         if (idx == '0) begin
            w.st.fpf = point_flag;
            if (cfg.split_action == ACT_PARTITION || cfg.split_action == ACT_SWITCH) begin
               case (cfg.initial_mode)
                  MODE_CONST:          w.st.run = cfg.initial_value;
                  MODE_CONST_PRESERVE: w.st.run = w.st.run ^ (cfg.initial_value == point_flag);
                  MODE_FIRST:          w.st.run = point_flag;
                  default:             w.st.run = ~point_flag;
               endcase
            end
         end

         case (cfg.split_action)
            ACT_SPLIT: begin
               if (!point_flag) begin
                  w = extend(w, idx);
               end else begin
                  w = close_open(w, 1'b1, cfg.closed_loop);
                  w = open_new(w, idx);
                  w.st.ocnt = 17'd1;
               end
            end
            ACT_REMOVE: begin
               if (!point_flag) w = extend(w, idx);
               else w = close_open(w, 1'b0, cfg.closed_loop);
            end
            ACT_DISCONNECT: begin
               if (!point_flag) w = extend(w, idx);
               else w = close_open(w, 1'b1, cfg.closed_loop);
            end
            ACT_PARTITION: begin
               if (point_flag != w.st.run) begin
                  w.st.run = ~w.st.run;
                  w = close_open(w, cfg.inclusive, cfg.closed_loop);
               end
               if (!w.st.open) begin
                  w = open_new(w, idx);
                  w.st.oeven = w.st.par;
                  w.st.par   = ~w.st.par;
               end
               w.st.ocnt = sat_add(w.st.ocnt, 17'd1);
            end
            ACT_SWITCH: begin
               if (point_flag) w.st.run = ~w.st.run;
               if (w.st.run) w = extend(w, idx);
               else w = close_open(w, cfg.inclusive, cfg.closed_loop);
            end
            default: ;
         endcase

         if (w.st.pc < MAX_PC) w.st.pc = w.st.pc + {{(CW-1){1'b0}}, 1'b1};

         if (!last_point) begin
            res.valid[0]                = w.pend.v && !(cfg.omit_single && w.pend.cnt == 17'd1);
            res.item[0].seg_start       = 16'(w.pend.start);
            res.item[0].seg_count       = w.pend.cnt;
            res.item[0].partition_even  = w.pend.even;
            res.item[0].last_of_run     = 1'b1;
            st_in                       = w.st;
         end else begin
            if (w.st.segs == 2'd1) begin
               c = w.st.hv ? w.st.hcnt : (w.pend.v ? w.pend.cnt : w.st.ocnt);
            end
            if (w.st.segs == 2'd0 || (w.st.segs == 2'd1 && NW'(c) == NW'(n))) begin
               res.valid[0]            = 1'b1;
               res.item[0].seg_count   = 17'(n);
               res.item[0].whole_input = 1'b1;
               res.item[0].last_of_run = 1'b1;
            end else begin
               wrap = w.st.hv && w.st.open;
               app  = !wrap && cfg.closed_loop;

               res.valid[0] = w.st.hv && !wrap && !(cfg.omit_single && w.st.hcnt == 17'd1);
               res.item[0].seg_start      = 16'(w.st.hstart);
               res.item[0].seg_count      = w.st.hcnt;
               res.item[0].partition_even = w.st.heven;

               res.valid[1] = w.pend.v && !(cfg.omit_single && w.pend.cnt == 17'd1);
               res.item[1].seg_start      = 16'(w.pend.start);
               res.item[1].seg_count      = w.pend.cnt;
               res.item[1].partition_even = w.pend.even;

               // open tail, wrapped onto the held segment or closed by point 0
               c = wrap ? sat_add(w.st.ocnt, w.st.hcnt)
                        : (app ? sat_add(w.st.ocnt, 17'd1) : w.st.ocnt);
               res.valid[2] = w.st.open && !(cfg.omit_single && c == 17'd1);
               res.item[2].seg_start      = 16'(w.st.ostart);
               res.item[2].seg_count      = c;
               res.item[2].appends_first  = app;
               res.item[2].wraps_to_start = wrap;
               res.item[2].partition_even = w.st.oeven;

               res.item[2].last_of_run = res.valid[2];
               res.item[1].last_of_run = res.valid[1] && !res.valid[2];
               res.item[0].last_of_run = res.valid[0] && !res.valid[1] && !res.valid[2];
            end
            st_in = ST_RESET;
         end
      end
   end

   assign push.item  = res.item;
   assign push.valid = res.valid & {3{accept}};

   assign status.path_idle = (st_ff.pc == '0) && !st_ff.open && !st_ff.hv;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

endmodule

### design/fdps_queue.sv
// result queue that takes up to three results a cycle and drains one while out_ready is high
module fdps_queue
   import fdps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   output logic             room,
   output logic             out_valid,
   input  logic             out_ready,
   output rsp_item_type     out_item,
   output queue_status_type status
);

   rsp_item_type mem [QUEUE_DEPTH];

   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] off1;
   logic [1:0] off2;
   logic [1:0] npush;
   logic       pop;

   assign off1  = {1'b0, push.valid[0]};
   assign off2  = {1'b0, push.valid[0]} + {1'b0, push.valid[1]};
   assign npush = off2 + {1'b0, push.valid[2]};
   assign pop   = out_valid && out_ready;

   assign wr_in    = wr_ff + npush;
   assign rd_in    = rd_ff + {1'b0, pop};
   assign count_in = count_ff + {1'b0, npush} - {2'b0, pop};

   assign room      = count_ff <= 3'(QUEUE_DEPTH - 3);
   assign out_valid = count_ff != 3'd0;
   assign out_item  = mem[rd_ff];
   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (push.valid[0]) mem[wr_ff] <= push.item[0];
      if (push.valid[1]) mem[wr_ff + off1] <= push.item[1];
      if (push.valid[2]) mem[wr_ff + off2] <= push.item[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/flag_driven_path_segmenter.sv
// top level of the flag driven path segmenter
// One request per path point, one flag each, taken at up to one per clock. Each point
// updates the segment tracking registers in the same cycle and any result it closes is
// written to a four-entry result queue, which registers it before it appears on rsp_. A
// mid-path point gives at most one result, the last point of a path up to three, and the
// queue drains one per clock while rsp_tready is high; req_tready is low while the queue holds
// more than one result, so after a last point with three results requests wait for the queue
// to drain. The user must write registers only between paths; the block does not enforce it.
module flag_driven_path_segmenter
   import fdps_pkg::*;
#(
   parameter int MAX_POINTS = 65536
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // point_flag
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // seg_start, seg_count
   output logic [3:0]  rsp_tuser,   // appends_first, wraps_to_start, whole_input, partition_even
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type          cfg;
   push_type         push;
   core_status_type  core_status;
   queue_status_type q_status;
   rsp_item_type     head;
   logic             room;
   logic             accept;

   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;

   fdps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   fdps_core #(
      .MAX_POINTS (MAX_POINTS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .point_flag (req_tdata[0]),
      .last_point (req_tlast),
      .cfg        (cfg),
      .push       (push),
      .status     (core_status)
   );

   fdps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head),
      .status    (q_status)
   );

   assign rsp_tdata = {7'd0, head.seg_count, head.seg_start};
   assign rsp_tuser = {head.partition_even, head.whole_input, head.wraps_to_start,
                       head.appends_first};
   assign rsp_tlast = head.last_of_run;

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= 3'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_path_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> core_status.path_idle)
      else $error("segment state not cleared after last point");

   a_valid_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid == (q_status.count != 3'd0))
      else $error("result valid does not match queue fill");
`endif

endmodule
